@@ hdl/clrp_pkg.sv @@
// Shared types, constants and register codes for the calorimeter log-ratio
// position block. No dependencies.
package clrp_pkg;

  localparam int ENERGY_BITS_DEF   = 20;
  localparam int LOG_FRAC_BITS_DEF = 10;

  // mantissa of the log unit: Q.30 in [1,2)
  localparam int MANT_BITS = 30;
  localparam int MW        = MANT_BITS + 1;

  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam int LANES = 4;  // x numerator, x denominator, y numerator, y denominator
  localparam int LANE_XA = 0;
  localparam int LANE_XB = 1;
  localparam int LANE_YA = 2;
  localparam int LANE_YB = 3;

  localparam int POS_W   = 16;
  localparam int THR_W   = 20;
  localparam int HALF_W  = 15;
  localparam int SIG_W   = 13;
  localparam int OFF_W   = 16;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PED_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_BLOCK    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_X_ONE     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_Y_ONE     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_X_TWO     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIG_Y_TWO     = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET      = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET      = 4'd7;

  localparam logic [THR_W-1:0]  RST_PED_THRESHOLD = 20'd320;
  localparam logic [HALF_W-1:0] RST_HALF_BLOCK    = 15'd5734;
  localparam logic [SIG_W-1:0]  RST_SIGMA         = 13'd1024;

  localparam logic [1:0] CASE_NONE    = 2'd0;
  localparam logic [1:0] CASE_A_EMPTY = 2'd1;
  localparam logic [1:0] CASE_B_EMPTY = 2'd2;
  localparam logic [1:0] CASE_BOTH    = 2'd3;

  typedef struct packed {
    logic [1:0] x_case;
    logic [1:0] y_case;
  } case_pair_t;

  typedef struct packed {
    logic [THR_W-1:0]         ped_threshold;
    logic [HALF_W-1:0]        half_block;
    logic [SIG_W-1:0]         sigma_x_one_side;
    logic [SIG_W-1:0]         sigma_y_one_side;
    logic [SIG_W-1:0]         sigma_x_two_side;
    logic [SIG_W-1:0]         sigma_y_two_side;
    logic signed [OFF_W-1:0]  x_offset;
    logic signed [OFF_W-1:0]  y_offset;
  } cfg_t;

endpackage

@@ hdl/clrp_in_if.sv @@
// Input channel: valid/ready plus the five cell energies.
// Depends on nothing.
interface clrp_in_if #(parameter int EB = 20);
  logic          valid;
  logic          ready;
  logic [EB-1:0] e_left;
  logic [EB-1:0] e_mid;
  logic [EB-1:0] e_right;
  logic [EB-1:0] e_upper;
  logic [EB-1:0] e_lower;
  modport source (output valid, e_left, e_mid, e_right, e_upper, e_lower, input ready);
  modport sink   (input valid, e_left, e_mid, e_right, e_upper, e_lower, output ready);
endinterface

@@ hdl/clrp_out_if.sv @@
// Result channel: valid/ready plus positions and case codes.
// Depends on nothing.
interface clrp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_pos;
  logic signed [15:0] y_pos;
  logic [1:0]         x_case;
  logic [1:0]         y_case;
  modport source (output valid, x_pos, y_pos, x_case, y_case, input ready);
  modport sink   (input valid, x_pos, y_pos, x_case, y_case, output ready);
endinterface

@@ hdl/clrp_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and data.
// Depends on nothing.
interface clrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/clrp_front.sv @@
// Front end: case decode, log operand selection, then leading-one search and
// mantissa normalization. Two pipeline stages. Uses clrp_pkg.
module clrp_front #(
  parameter int EB = 20,
  parameter int PW = 5
) (
  input  logic                   clk,
  input  logic [1:0]             en,
  input  logic [EB-1:0]          e_left,
  input  logic [EB-1:0]          e_mid,
  input  logic [EB-1:0]          e_right,
  input  logic [EB-1:0]          e_upper,
  input  logic [EB-1:0]          e_lower,
  input  logic [clrp_pkg::THR_W-1:0] thr,
  output clrp_pkg::case_pair_t   cs_o,
  output logic [PW-1:0]          p_o [clrp_pkg::LANES],
  output logic [clrp_pkg::MW-1:0] m_o [clrp_pkg::LANES]
);
  import clrp_pkg::*;

  localparam int OPW = EB + 2;
  localparam int CW  = (EB > THR_W) ? EB : THR_W;

  logic [OPW-1:0] op_r  [LANES];
  logic [OPW-1:0] op_nxt[LANES];
  case_pair_t     cs0_r, cs0_nxt;
  case_pair_t     cs1_r;
  logic [PW-1:0]  p_r   [LANES];
  logic [MW-1:0]  m_r   [LANES];
  logic [PW-1:0]  p_nxt [LANES];
  logic [MW-1:0]  m_nxt [LANES];

  function automatic logic [1:0] axis_case(input logic [CW-1:0] a, input logic [CW-1:0] mid,
                                           input logic [CW-1:0] b, input logic [CW-1:0] t);
    logic [1:0] c;
    if (a < t && b > t && mid > t)      c = CASE_A_EMPTY;
    else if (a > t && b < t && mid > t) c = CASE_B_EMPTY;
    else if (a > t && b > t)            c = CASE_BOTH;
    else                                c = CASE_NONE;
    return c;
  endfunction

  function automatic void axis_ops(input logic [1:0] c, input logic [EB-1:0] a,
                                   input logic [EB-1:0] mid, input logic [EB-1:0] b,
                                   output logic [OPW-1:0] na, output logic [OPW-1:0] nb);
    logic [OPW-1:0] mid_e, a2, b2;
    mid_e = {2'b00, mid};
    a2    = {1'b0, a, 1'b0};
    b2    = {1'b0, b, 1'b0};
    case (c)
      CASE_A_EMPTY: begin na = mid_e + b2; nb = b2; end
      CASE_B_EMPTY: begin na = mid_e + a2; nb = a2; end
      CASE_BOTH:    begin na = {2'b00, a}; nb = {2'b00, b}; end
      default:      begin na = OPW'(1); nb = OPW'(1); end
    endcase
  endfunction

  always_comb begin
    logic [CW-1:0] t, l, m, r, u, lo;
    t  = {{(CW-THR_W){1'b0}}, thr};
    l  = {{(CW-EB){1'b0}}, e_left};
    m  = {{(CW-EB){1'b0}}, e_mid};
    r  = {{(CW-EB){1'b0}}, e_right};
    u  = {{(CW-EB){1'b0}}, e_upper};
    lo = {{(CW-EB){1'b0}}, e_lower};
    cs0_nxt.x_case = axis_case(l, m, r, t);
    cs0_nxt.y_case = axis_case(lo, m, u, t);
    axis_ops(cs0_nxt.x_case, e_left, e_mid, e_right, op_nxt[LANE_XA], op_nxt[LANE_XB]);
    axis_ops(cs0_nxt.y_case, e_lower, e_mid, e_upper, op_nxt[LANE_YA], op_nxt[LANE_YB]);
  end

  // leading one and shift to Q.30
  always_comb begin
    logic [63:0] t;
    for (int k = 0; k < LANES; k++) begin
      p_nxt[k] = '0;
      for (int i = 0; i < OPW; i++) begin
        if (op_r[k][i]) p_nxt[k] = i[PW-1:0];
      end
      t = {{(64-OPW){1'b0}}, op_r[k]};
      if (int'(p_nxt[k]) <= MANT_BITS) t = t << (MANT_BITS - int'(p_nxt[k]));
      else                              t = t >> (int'(p_nxt[k]) - MANT_BITS);
      m_nxt[k] = t[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      op_r  <= op_nxt;
      cs0_r <= cs0_nxt;
    end
    if (en[1]) begin
      p_r   <= p_nxt;
      m_r   <= m_nxt;
      cs1_r <= cs0_r;
    end
  end

  assign cs_o = cs1_r;
  assign p_o  = p_r;
  assign m_o  = m_r;
endmodule

@@ hdl/clrp_log_cell.sv @@
// One cell of the log2 chain: squares each lane's mantissa once and shifts
// one fraction bit into its log. Uses clrp_pkg.
module clrp_log_cell #(
  parameter int PW  = 5,
  parameter int LFB = 10
) (
  input  logic                    clk,
  input  logic                    en,
  input  clrp_pkg::case_pair_t    cs_i,
  input  logic [PW-1:0]           p_i [clrp_pkg::LANES],
  input  logic [clrp_pkg::MW-1:0] m_i [clrp_pkg::LANES],
  input  logic [LFB-1:0]          f_i [clrp_pkg::LANES],
  output clrp_pkg::case_pair_t    cs_o,
  output logic [PW-1:0]           p_o [clrp_pkg::LANES],
  output logic [clrp_pkg::MW-1:0] m_o [clrp_pkg::LANES],
  output logic [LFB-1:0]          f_o [clrp_pkg::LANES]
);
  import clrp_pkg::*;

  case_pair_t     cs_r;
  logic [PW-1:0]  p_r  [LANES];
  logic [MW-1:0]  m_r  [LANES];
  logic [LFB-1:0] f_r  [LANES];
  logic [MW-1:0]  m_nxt[LANES];
  logic [LFB-1:0] f_nxt[LANES];

  always_comb begin
    logic [2*MW-1:0] sq;
    logic            hi;
    for (int k = 0; k < LANES; k++) begin
      sq = (2*MW)'(m_i[k]) * (2*MW)'(m_i[k]);
      hi = sq[2*MANT_BITS+1];  // square reached 2.0
      m_nxt[k] = hi ? sq[2*MANT_BITS+1 -: MW] : sq[2*MANT_BITS -: MW];
      f_nxt[k] = {f_i[k][LFB-2:0], hi};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cs_r <= cs_i;
      p_r  <= p_i;
      m_r  <= m_nxt;
      f_r  <= f_nxt;
    end
  end

  assign cs_o = cs_r;
  assign p_o  = p_r;
  assign m_o  = m_r;
  assign f_o  = f_r;
endmodule

@@ hdl/clrp_back.sv @@
// Back end: log difference, scaling by ln2 and sigma, rounding, offset add and
// saturation. Five stages, the last one is the output register. Uses clrp_pkg.
module clrp_back #(
  parameter int PW  = 5,
  parameter int LFB = 10
) (
  input  logic                   clk,
  input  logic [4:0]             en,
  input  clrp_pkg::cfg_t         cfg,
  input  clrp_pkg::case_pair_t   cs_i,
  input  logic [PW-1:0]          p_i [clrp_pkg::LANES],
  input  logic [LFB-1:0]         f_i [clrp_pkg::LANES],
  output clrp_pkg::case_pair_t   cs_o,
  output logic signed [clrp_pkg::POS_W-1:0] x_pos,
  output logic signed [clrp_pkg::POS_W-1:0] y_pos
);
  import clrp_pkg::*;

  localparam int LW   = PW + LFB;
  localparam int P1W  = LW + 16;
  localparam int P2W  = P1W + SIG_W;
  localparam int RW   = P2W + 1 - (LFB + 16);
  localparam int SUMW = RW + 3;

  case_pair_t cs_r [5];
  logic [1:0]     neg_r [4];
  logic [LW-1:0]  mag_r [2];
  logic [P1W-1:0] p1_r  [2];
  logic [P2W-1:0] p2_r  [2];
  logic [RW-1:0]  rnd_r [2];
  logic signed [POS_W-1:0] pos_r [2];

  logic [LW-1:0]  mag_nxt[2];
  logic [1:0]     neg_nxt;
  logic [P2W-1:0] p2_nxt [2];
  logic [RW-1:0]  rnd_nxt[2];
  logic signed [POS_W-1:0] pos_nxt[2];

  function automatic logic [1:0] case_of(input case_pair_t c, input int ax);
    return (ax == 0) ? c.x_case : c.y_case;
  endfunction

  always_comb begin
    logic signed [LW:0] d;
    for (int ax = 0; ax < 2; ax++) begin
      d = $signed({1'b0, p_i[2*ax], f_i[2*ax]}) - $signed({1'b0, p_i[2*ax+1], f_i[2*ax+1]});
      neg_nxt[ax] = d[LW];
      mag_nxt[ax] = d[LW] ? LW'(-d) : d[LW-1:0];
    end
  end

  always_comb begin
    logic [SIG_W-1:0] s;
    for (int ax = 0; ax < 2; ax++) begin
      if (case_of(cs_r[1], ax) == CASE_BOTH)
        s = (ax == 0) ? cfg.sigma_x_two_side : cfg.sigma_y_two_side;
      else
        s = (ax == 0) ? cfg.sigma_x_one_side : cfg.sigma_y_one_side;
      p2_nxt[ax] = P2W'(p1_r[ax]) * P2W'(s);
    end
  end

  // round half away from zero on the magnitude; both-sides case halves too
  always_comb begin
    logic [P2W:0] sum;
    for (int ax = 0; ax < 2; ax++) begin
      if (case_of(cs_r[2], ax) == CASE_BOTH) begin
        sum = {1'b0, p2_r[ax]} + ((P2W+1)'(1) << (LFB + 16));
        rnd_nxt[ax] = RW'(sum >> (LFB + 17));
      end else begin
        sum = {1'b0, p2_r[ax]} + ((P2W+1)'(1) << (LFB + 15));
        rnd_nxt[ax] = RW'(sum >> (LFB + 16));
      end
    end
  end

  always_comb begin
    logic signed [SUMW-1:0] c, h, o, s;
    for (int ax = 0; ax < 2; ax++) begin
      c = $signed({3'b000, rnd_r[ax]});
      if (neg_r[3][ax]) c = -c;
      h = $signed({{(SUMW-HALF_W){1'b0}}, cfg.half_block});
      o = (ax == 0) ? {{(SUMW-OFF_W){cfg.x_offset[OFF_W-1]}}, cfg.x_offset}
                    : {{(SUMW-OFF_W){cfg.y_offset[OFF_W-1]}}, cfg.y_offset};
      case (case_of(cs_r[3], ax))
        CASE_A_EMPTY: s = h - c + o;
        CASE_B_EMPTY: s = c - h + o;
        CASE_BOTH:    s = c + o;
        default:      s = '0;
      endcase
      if (s > $signed(SUMW'(32767)))       pos_nxt[ax] = 16'sh7fff;
      else if (s < $signed(SUMW'(-32768))) pos_nxt[ax] = -16'sh8000;
      else                                 pos_nxt[ax] = s[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cs_r[0]  <= cs_i;
      neg_r[0] <= neg_nxt;
      mag_r    <= mag_nxt;
    end
    if (en[1]) begin
      cs_r[1]  <= cs_r[0];
      neg_r[1] <= neg_r[0];
      for (int ax = 0; ax < 2; ax++) p1_r[ax] <= P1W'(mag_r[ax]) * P1W'(LN2_Q16);
    end
    if (en[2]) begin
      cs_r[2]  <= cs_r[1];
      neg_r[2] <= neg_r[1];
      p2_r     <= p2_nxt;
    end
    if (en[3]) begin
      cs_r[3]  <= cs_r[2];
      neg_r[3] <= neg_r[2];
      rnd_r    <= rnd_nxt;
    end
    if (en[4]) begin
      cs_r[4]  <= cs_r[3];
      pos_r    <= pos_nxt;
    end
  end

  assign cs_o  = cs_r[4];
  assign x_pos = pos_r[0];
  assign y_pos = pos_r[1];
endmodule

@@ hdl/calorimeter_log_ratio_position.sv @@
// Top level: config registers, per-stage handshake, front end, chain of log
// cells and back end. Uses clrp_pkg, the channel interfaces and submodules.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          e_left e_mid e_right e_upper e_lower
//   out_ch   out  valid/ready          x_pos y_pos x_case y_case
//   cfg_ch   in   valid/ready (=1)     index data
//
// One item per cycle sustained while the output is ready; LOG_FRAC_BITS + 7
// register stages (two front stages, one log cell per fraction bit, five back
// stages).
// Each stage holds when it is full and the one after it holds, so bubbles
// close up while the output is stalled. Reset clears the stage valid bits and
// restores the register defaults.
module calorimeter_log_ratio_position #(
  parameter int ENERGY_BITS   = clrp_pkg::ENERGY_BITS_DEF,
  parameter int LOG_FRAC_BITS = clrp_pkg::LOG_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  clrp_in_if.sink    in_ch,
  clrp_out_if.source out_ch,
  clrp_cfg_if.sink   cfg_ch
);
  import clrp_pkg::*;

  localparam int LFB = LOG_FRAC_BITS;
  localparam int PW  = $clog2(ENERGY_BITS + 2);
  localparam int NS  = 2 + LFB + 5;

  cfg_t cfg_r;
  logic [NS-1:0] v_r, v_nxt, en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ped_threshold    <= RST_PED_THRESHOLD;
      cfg_r.half_block       <= RST_HALF_BLOCK;
      cfg_r.sigma_x_one_side <= RST_SIGMA;
      cfg_r.sigma_y_one_side <= RST_SIGMA;
      cfg_r.sigma_x_two_side <= RST_SIGMA;
      cfg_r.sigma_y_two_side <= RST_SIGMA;
      cfg_r.x_offset         <= '0;
      cfg_r.y_offset         <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_PED_THRESHOLD: cfg_r.ped_threshold    <= cfg_ch.data[THR_W-1:0];
        REG_HALF_BLOCK:    cfg_r.half_block       <= cfg_ch.data[HALF_W-1:0];
        REG_SIG_X_ONE:     cfg_r.sigma_x_one_side <= cfg_ch.data[SIG_W-1:0];
        REG_SIG_Y_ONE:     cfg_r.sigma_y_one_side <= cfg_ch.data[SIG_W-1:0];
        REG_SIG_X_TWO:     cfg_r.sigma_x_two_side <= cfg_ch.data[SIG_W-1:0];
        REG_SIG_Y_TWO:     cfg_r.sigma_y_two_side <= cfg_ch.data[SIG_W-1:0];
        REG_X_OFFSET:      cfg_r.x_offset         <= $signed(cfg_ch.data[OFF_W-1:0]);
        REG_Y_OFFSET:      cfg_r.y_offset         <= $signed(cfg_ch.data[OFF_W-1:0]);
        default: ;
      endcase
    end
  end
  assign cfg_ch.ready = 1'b1;

  // a stage loads when it is empty or its successor loads
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
    for (int i = 0; i < NS; i++) begin
      if (en[i]) v_nxt[i] = (i == 0) ? in_ch.valid : v_r[i-1];
      else       v_nxt[i] = v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else        v_r <= v_nxt;
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = v_r[NS-1];

  case_pair_t    cc [LFB+1];
  logic [PW-1:0] cp [LFB+1][LANES];
  logic [MW-1:0] cm [LFB+1][LANES];
  logic [LFB-1:0] cf [LFB+1][LANES];
  case_pair_t    cs_out;

  clrp_front #(.EB(ENERGY_BITS), .PW(PW)) u_front (
    .clk     (clk),
    .en      (en[1:0]),
    .e_left  (in_ch.e_left),
    .e_mid   (in_ch.e_mid),
    .e_right (in_ch.e_right),
    .e_upper (in_ch.e_upper),
    .e_lower (in_ch.e_lower),
    .thr     (cfg_r.ped_threshold),
    .cs_o    (cc[0]),
    .p_o     (cp[0]),
    .m_o     (cm[0])
  );

  always_comb begin
    for (int k = 0; k < LANES; k++) cf[0][k] = '0;
  end

  for (genvar g = 0; g < LFB; g++) begin : g_cell
    clrp_log_cell #(.PW(PW), .LFB(LFB)) u_cell (
      .clk  (clk),
      .en   (en[2+g]),
      .cs_i (cc[g]),
      .p_i  (cp[g]),
      .m_i  (cm[g]),
      .f_i  (cf[g]),
      .cs_o (cc[g+1]),
      .p_o  (cp[g+1]),
      .m_o  (cm[g+1]),
      .f_o  (cf[g+1])
    );
  end

  clrp_back #(.PW(PW), .LFB(LFB)) u_back (
    .clk   (clk),
    .en    (en[NS-1:NS-5]),
    .cfg   (cfg_r),
    .cs_i  (cc[LFB]),
    .p_i   (cp[LFB]),
    .f_i   (cf[LFB]),
    .cs_o  (cs_out),
    .x_pos (out_ch.x_pos),
    .y_pos (out_ch.y_pos)
  );

  assign out_ch.x_case = cs_out.x_case;
  assign out_ch.y_case = cs_out.y_case;

  // input only stalls when the whole pipe is full behind a stalled output
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready && (&v_r)))
    else $error("input stalled with room in the pipeline");

  a_x_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.x_case == CASE_NONE) |-> out_ch.x_pos == 16'sd0)
    else $error("x position nonzero with no case");

  a_y_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.y_case == CASE_NONE) |-> out_ch.y_pos == 16'sd0)
    else $error("y position nonzero with no case");
endmodule
